// ===== rtl/sbpf_pkg.sv =====
// ----------------------------------------------------------------------------
// sbpf_pkg: shared types and codes for the servo bus packet framer
// Command, status and instruction codes, the front/back queue entry and the
// request packet helpers.
// ----------------------------------------------------------------------------
package sbpf_pkg;

   localparam int QueueDepthDefault = 4;

   typedef logic [2:0] command_type;
   localparam command_type CMD_PING       = 3'd0;
   localparam command_type CMD_READ16     = 3'd1;
   localparam command_type CMD_WRITE8     = 3'd2;
   localparam command_type CMD_WRITE16    = 3'd3;
   localparam command_type CMD_RX_BYTE    = 3'd4;
   localparam command_type CMD_RX_TIMEOUT = 3'd5;

   // request kind as carried in the queue: low bits of a request command
   typedef logic [1:0] req_kind_type;
   localparam req_kind_type REQ_PING    = 2'd0;
   localparam req_kind_type REQ_READ16  = 2'd1;
   localparam req_kind_type REQ_WRITE8  = 2'd2;
   localparam req_kind_type REQ_WRITE16 = 2'd3;

   typedef logic [1:0] status_type;
   localparam status_type STATUS_OK         = 2'd0;
   localparam status_type STATUS_BAD_HEADER = 2'd1;
   localparam status_type STATUS_SHORT      = 2'd2;
   localparam status_type STATUS_TIMEOUT    = 2'd3;

   localparam logic KIND_TX   = 1'b0;
   localparam logic KIND_DONE = 1'b1;

   localparam logic [7:0] HEADER_BYTE  = 8'hFF;
   localparam logic [7:0] INSTR_PING   = 8'h01;
   localparam logic [7:0] INSTR_READ   = 8'h02;
   localparam logic [7:0] INSTR_WRITE  = 8'h03;
   localparam logic [7:0] READ_COUNT   = 8'h02;
   localparam logic [1:0] READ_DATA_BYTES = 2'd2;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_HDR0,
      PH_HDR1,
      PH_ID,
      PH_LEN,
      PH_BODY
   } rx_phase_type;

   typedef struct packed {
      logic         is_done;
      req_kind_type req;
      logic [7:0]   servo_id;
      logic [7:0]   reg_addr;
      logic [15:0]  write_value;
      logic [7:0]   checksum;
      status_type   status;
      logic [15:0]  read_data;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // length byte: parameter count plus two
   function automatic logic [7:0] pkt_length(input req_kind_type req);
      logic [7:0] len;
      case (req)
         REQ_PING:    len = 8'd2;
         REQ_WRITE16: len = 8'd5;
         default:     len = 8'd4;
      endcase
      return len;
   endfunction

   function automatic logic [7:0] pkt_instr(input req_kind_type req);
      logic [7:0] ins;
      case (req)
         REQ_PING:   ins = INSTR_PING;
         REQ_READ16: ins = INSTR_READ;
         default:    ins = INSTR_WRITE;
      endcase
      return ins;
   endfunction

endpackage

// ===== rtl/sbpf_front.sv =====
// ----------------------------------------------------------------------------
// sbpf_front: request classifier and response deframer
// Accept items, build request descriptors with their checksum and track the
// response header and body; push one queue entry per packet or completion.
// ----------------------------------------------------------------------------
module sbpf_front
   import sbpf_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  command_type      command,
   input  logic [7:0]       servo_id,
   input  logic [7:0]       reg_addr,
   input  logic [15:0]      write_value,
   input  logic [7:0]       rx_byte,
   input  queue_status_type queue_status,
   output logic             push,
   output entry_type        push_entry
);

   rx_phase_type rx_phase_ff, rx_phase_in;
   logic [1:0]   expected_ff, expected_in;
   logic [7:0]   bytes_left_ff, bytes_left_in;
   logic [7:0]   body_index_ff, body_index_in;
   logic [7:0]   body_length_ff, body_length_in;
   logic [15:0]  data_word_ff, data_word_in;
   logic         header_bad_ff, header_bad_in;

   logic         accept;
   logic         is_request;
   logic [7:0]   bytes_left_dec;
   logic [7:0]   param_sum;
   logic [7:0]   byte_sum;

   assign req_tready     = !queue_status.full;
   assign accept         = req_tvalid && req_tready;
   assign is_request     = !command[2];
   assign bytes_left_dec = bytes_left_ff - 8'd1;

   // checksum over id, length, instruction and parameters
   always_comb begin
      case (req_kind_type'(command[1:0]))
         REQ_READ16:  param_sum = reg_addr + READ_COUNT;
         REQ_WRITE8:  param_sum = reg_addr + write_value[7:0];
         REQ_WRITE16: param_sum = reg_addr + write_value[7:0] + write_value[15:8];
         default:     param_sum = 8'd0;
      endcase
      byte_sum = servo_id + pkt_length(req_kind_type'(command[1:0]))
               + pkt_instr(req_kind_type'(command[1:0])) + param_sum;
   end

   // next state of the response deframer
   always_comb begin
      rx_phase_in = rx_phase_ff;
      if (accept) begin
         if (is_request) begin
            rx_phase_in = PH_HDR0;
         end else begin
            case (command)
               CMD_RX_TIMEOUT: begin
                  rx_phase_in = PH_IDLE;
               end
               CMD_RX_BYTE: begin
                  case (rx_phase_ff)
                     PH_IDLE: rx_phase_in = PH_IDLE;
                     PH_HDR0: rx_phase_in = PH_HDR1;
                     PH_HDR1: rx_phase_in = PH_ID;
                     PH_ID:   rx_phase_in = PH_LEN;
                     PH_LEN: begin
                        if (header_bad_ff || rx_byte == 8'd0) rx_phase_in = PH_IDLE;
                        else rx_phase_in = PH_BODY;
                     end
                     PH_BODY: begin
                        if (bytes_left_dec == 8'd0) rx_phase_in = PH_IDLE;
                     end
                     default: rx_phase_in = PH_IDLE;
                  endcase
               end
               default: rx_phase_in = rx_phase_ff;
            endcase
         end
      end
   end

   // deframer datapath and queue entries
   always_comb begin
      expected_in    = expected_ff;
      bytes_left_in  = bytes_left_ff;
      body_index_in  = body_index_ff;
      body_length_in = body_length_ff;
      data_word_in   = data_word_ff;
      header_bad_in  = header_bad_ff;
      push           = 1'b0;
      push_entry     = '0;
      push_entry.servo_id    = servo_id;
      push_entry.reg_addr    = reg_addr;
      push_entry.write_value = write_value;
      push_entry.req         = req_kind_type'(command[1:0]);
      push_entry.checksum    = ~byte_sum;
      if (accept) begin
         if (is_request) begin
            expected_in    = (command == CMD_READ16) ? READ_DATA_BYTES : 2'd0;
            bytes_left_in  = 8'd0;
            body_index_in  = 8'd0;
            body_length_in = 8'd0;
            data_word_in   = 16'd0;
            header_bad_in  = 1'b0;
            push           = 1'b1;
            push_entry.is_done = KIND_TX;
         end else begin
            case (command)
               CMD_RX_TIMEOUT: begin
                  if (rx_phase_ff != PH_IDLE) begin
                     push               = 1'b1;
                     push_entry.is_done = KIND_DONE;
                     push_entry.status  = STATUS_TIMEOUT;
                  end
               end
               CMD_RX_BYTE: begin
                  case (rx_phase_ff)
                     PH_HDR0, PH_HDR1: begin
                        if (rx_byte != HEADER_BYTE) header_bad_in = 1'b1;
                     end
                     PH_LEN: begin
                        if (header_bad_ff) begin
                           push               = 1'b1;
                           push_entry.is_done = KIND_DONE;
                           push_entry.status  = STATUS_BAD_HEADER;
                        end else begin
                           body_length_in = rx_byte;
                           bytes_left_in  = rx_byte;
                           body_index_in  = 8'd0;
                           data_word_in   = 16'd0;
                           if (rx_byte == 8'd0) begin
                              push               = 1'b1;
                              push_entry.is_done = KIND_DONE;
                              push_entry.status  = STATUS_SHORT;
                           end
                        end
                     end
                     PH_BODY: begin
                        // collect the first two parameters, little-endian
                        if (body_index_ff == 8'd1) data_word_in[7:0] = rx_byte;
                        else if (body_index_ff == 8'd2) data_word_in[15:8] = rx_byte;
                        if (body_index_ff != 8'hFF) body_index_in = body_index_ff + 8'd1;
                        bytes_left_in = bytes_left_dec;
                        if (bytes_left_dec == 8'd0) begin
                           push               = 1'b1;
                           push_entry.is_done = KIND_DONE;
                           if (body_length_ff < 8'(expected_ff) + 8'd2) begin
                              push_entry.status = STATUS_SHORT;
                           end else begin
                              push_entry.status = STATUS_OK;
                              if (expected_ff == READ_DATA_BYTES)
                                 push_entry.read_data = data_word_in;
                           end
                        end
                     end
                     default: push = 1'b0;
                  endcase
               end
               default: push = 1'b0;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_phase_ff    <= PH_IDLE;
         expected_ff    <= 2'd0;
         bytes_left_ff  <= 8'd0;
         body_index_ff  <= 8'd0;
         body_length_ff <= 8'd0;
         data_word_ff   <= 16'd0;
         header_bad_ff  <= 1'b0;
      end else begin
         rx_phase_ff    <= rx_phase_in;
         expected_ff    <= expected_in;
         bytes_left_ff  <= bytes_left_in;
         body_index_ff  <= body_index_in;
         body_length_ff <= body_length_in;
         data_word_ff   <= data_word_in;
         header_bad_ff  <= header_bad_in;
      end
   end

endmodule

// ===== rtl/sbpf_fifo.sv =====
// ----------------------------------------------------------------------------
// sbpf_fifo: entry queue between front and back
// Small register queue; full and empty come from a registered count.
// ----------------------------------------------------------------------------
module sbpf_fifo
   import sbpf_pkg::*;
#(
   parameter int DEPTH = QueueDepthDefault
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  entry_type        push_entry,
   input  logic             pop,
   output entry_type        pop_entry,
   output queue_status_type queue_status
);

   localparam int PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntWidth = $clog2(DEPTH + 1);
   localparam logic [PtrWidth-1:0] PtrLast = PtrWidth'(DEPTH - 1);
   localparam logic [CntWidth-1:0] CntFull = CntWidth'(DEPTH);
   localparam logic [PtrWidth-1:0] PtrOne  = PtrWidth'(1);
   localparam logic [CntWidth-1:0] CntOne  = CntWidth'(1);

   entry_type             store_ff [DEPTH];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]   count_ff, count_in;
   logic                  do_push, do_pop;

   assign queue_status.full  = (count_ff == CntFull);
   assign queue_status.empty = (count_ff == '0);
   assign do_push   = push && !queue_status.full;
   assign do_pop    = pop && !queue_status.empty;
   assign pop_entry = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + PtrOne;
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + PtrOne;
      if (do_push && !do_pop) count_in = count_ff + CntOne;
      else if (do_pop && !do_push) count_in = count_ff - CntOne;
   end

   always_ff @(posedge clock) begin
      if (do_push) store_ff[wr_ptr_ff] <= push_entry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/sbpf_back.sv =====
// ----------------------------------------------------------------------------
// sbpf_back: packet serializer and result register
// Walk a request entry byte by byte, or pass a completion, into the
// registered result stage.
// ----------------------------------------------------------------------------
module sbpf_back
   import sbpf_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  entry_type        entry,
   input  queue_status_type queue_status,
   output logic             pop,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic             result_kind,
   output logic [7:0]       tx_byte,
   output logic             last_byte,
   output status_type       status,
   output logic [15:0]      read_data
);

   logic [3:0]  byte_idx_ff, byte_idx_in;
   logic        valid_ff, valid_in;
   logic        kind_ff, kind_in;
   logic [7:0]  tx_ff, tx_in;
   logic        last_ff, last_in;
   status_type  status_ff, status_in;
   logic [15:0] data_ff, data_in;

   logic        load;
   logic        go;
   logic [3:0]  last_idx;
   logic [7:0]  cur_byte;
   logic        at_last;

   assign load = !valid_ff || rsp_tready;
   assign go   = load && !queue_status.empty;

   always_comb begin
      case (entry.req)
         REQ_PING:    last_idx = 4'd5;
         REQ_WRITE16: last_idx = 4'd8;
         default:     last_idx = 4'd7;
      endcase
   end

   assign at_last = (byte_idx_ff == last_idx);

   // pick the packet byte at the current index
   always_comb begin
      case (byte_idx_ff)
         4'd0, 4'd1: cur_byte = HEADER_BYTE;
         4'd2:       cur_byte = entry.servo_id;
         4'd3:       cur_byte = pkt_length(entry.req);
         4'd4:       cur_byte = pkt_instr(entry.req);
         4'd5:       cur_byte = entry.reg_addr;
         4'd6:       cur_byte = (entry.req == REQ_READ16) ? READ_COUNT
                                                         : entry.write_value[7:0];
         4'd7:       cur_byte = entry.write_value[15:8];
         default:    cur_byte = 8'd0;
      endcase
      if (at_last) cur_byte = entry.checksum;
   end

   always_comb begin
      byte_idx_in = byte_idx_ff;
      valid_in    = valid_ff;
      kind_in     = kind_ff;
      tx_in       = tx_ff;
      last_in     = last_ff;
      status_in   = status_ff;
      data_in     = data_ff;
      pop         = 1'b0;
      if (go) begin
         valid_in = 1'b1;
         if (entry.is_done) begin
            kind_in   = KIND_DONE;
            tx_in     = 8'd0;
            last_in   = 1'b0;
            status_in = entry.status;
            data_in   = entry.read_data;
            pop       = 1'b1;
         end else begin
            kind_in   = KIND_TX;
            tx_in     = cur_byte;
            last_in   = at_last;
            status_in = STATUS_OK;
            data_in   = 16'd0;
            if (at_last) begin
               pop         = 1'b1;
               byte_idx_in = 4'd0;
            end else begin
               byte_idx_in = byte_idx_ff + 4'd1;
            end
         end
      end else if (load) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_idx_ff <= 4'd0;
         valid_ff    <= 1'b0;
      end else begin
         byte_idx_ff <= byte_idx_in;
         valid_ff    <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      tx_ff     <= tx_in;
      last_ff   <= last_in;
      status_ff <= status_in;
      data_ff   <= data_in;
   end

   assign rsp_tvalid  = valid_ff;
   assign result_kind = kind_ff;
   assign tx_byte     = tx_ff;
   assign last_byte   = last_ff;
   assign status      = status_ff;
   assign read_data   = data_ff;

endmodule

// ===== rtl/servo_bus_packet_framer_core.sv =====
// ----------------------------------------------------------------------------
// servo_bus_packet_framer_core: half-duplex servo bus master framer
// Frame ping, read16, write8 and write16 requests into transmit byte runs and
// deframe response bytes into completions with status and read data.
// ----------------------------------------------------------------------------
//
// Channel  Dir  tuser                 tlast       tdata
// req_     in   [2:0] command         -           servo_id, reg_addr, write_value, rx_byte
// rsp_     out  [0] result_kind       last_byte   tx_byte, status, read_data
//
// The front takes one item per clock whenever the entry queue has room; it
// runs the response deframer and builds one queue entry per request packet or
// completion. The back drains one result item per clock, while the result
// side is ready, into the output register; a request packet gives 6, 8 or 9
// transmit bytes, set by the byte serializer. Reset is synchronous and active
// high and empties the queue and deframer. A stalled result side fills the
// queue, then drops req_tready; items already queued are kept in order.
//
module servo_bus_packet_framer_core
   import sbpf_pkg::*;
#(
   parameter int QUEUE_DEPTH = QueueDepthDefault
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [2:0]  req_tuser,   // [2:0] command
   input  logic [39:0] req_tdata,   // servo_id, reg_addr, write_value, rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [0:0]  rsp_tuser,   // [0] result_kind
   output logic        rsp_tlast,   // last_byte
   output logic [31:0] rsp_tdata    // tx_byte, status, read_data, zero pad
);

   queue_status_type queue_status;
   logic             push;
   logic             pop;
   entry_type        push_entry;
   entry_type        pop_entry;
   logic             result_kind;
   logic [7:0]       tx_byte;
   status_type       status;
   logic [15:0]      read_data;

   // classify requests and deframe received bytes
   sbpf_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .command      (req_tuser),
      .servo_id     (req_tdata[7:0]),
      .reg_addr     (req_tdata[15:8]),
      .write_value  (req_tdata[31:16]),
      .rx_byte      (req_tdata[39:32]),
      .queue_status (queue_status),
      .push         (push),
      .push_entry   (push_entry)
   );

   // decouple the two sides
   sbpf_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .push_entry   (push_entry),
      .pop          (pop),
      .pop_entry    (pop_entry),
      .queue_status (queue_status)
   );

   // serialize packets and hand out completions
   sbpf_back u_back (
      .clock        (clock),
      .reset        (reset),
      .entry        (pop_entry),
      .queue_status (queue_status),
      .pop          (pop),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .result_kind  (result_kind),
      .tx_byte      (tx_byte),
      .last_byte    (rsp_tlast),
      .status       (status),
      .read_data    (read_data)
   );

   assign rsp_tuser = result_kind;
   assign rsp_tdata = {6'd0, read_data, status, tx_byte};

endmodule
